### rtl/servo_sine_blend_trajectory_defines.svh
// Assertion macros used by the checker file.
// Both expect signals named clk and rst_n in the scope where they are used.
`ifndef SERVO_SINE_BLEND_TRAJECTORY_DEFINES_SVH
`define SERVO_SINE_BLEND_TRAJECTORY_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SSBT_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ssbt: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define SSBT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ssbt: next-cycle check failed");

`endif

### rtl/ssbt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ssbt_pkg;

    // Configuration register indexes
    localparam logic [2:0] CFG_TRIM   = 3'd0;
    localparam logic [2:0] CFG_PMIN   = 3'd1;
    localparam logic [2:0] CFG_PMAX   = 3'd2;
    localparam logic [2:0] CFG_WEIGHT = 3'd3;
    localparam logic [2:0] CFG_TICK   = 3'd4;

    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 64;
    localparam int ANGLE_W     = 8;
    localparam int CFG_PULSE_W = 12;
    localparam int OUT_W       = 12;
    localparam int WEIGHT_W    = 9;
    localparam int TICK_W      = 8;
    localparam int MS_W        = 16;
    localparam int FRAC_BITS   = 16;
    localparam int FRAC_W      = FRAC_BITS + 1;
    localparam int NUM_PORTS   = 8;

    localparam logic [ANGLE_W-1:0]  ANGLE_MAX   = 8'd180;
    localparam logic [WEIGHT_W-1:0] WEIGHT_FULL = 9'd256;
    localparam int unsigned PULSE_RESET = 1500;
    localparam logic [CFG_PULSE_W-1:0] PMIN_RESET = 12'd500;
    localparam logic [CFG_PULSE_W-1:0] PMAX_RESET = 12'd2500;
    localparam logic [WEIGHT_W-1:0]    WEIGHT_RESET = 9'd128;
    localparam logic [TICK_W-1:0]      TICK_RESET = 8'd20;

    // Shared multiplier operand and product widths
    localparam int MUL_W  = 19;
    localparam int PROD_W = 2 * MUL_W;
    typedef logic [MUL_W-1:0]  mul_op_t;
    typedef logic [PROD_W-1:0] prod_t;

    // x / 180 is done as (x >> 2) * RECIP_45 >> RECIP_SHIFT, exact for x < 2^20
    localparam int RECIP_SHIFT = 24;
    localparam mul_op_t RECIP_45 = mul_op_t'(((2 ** 24) + 44) / 45);

    // Iterative divider
    localparam int DIV_NUM_W = 32;
    localparam int DIV_DEN_W = 16;
    localparam int DIV_STEPS = DIV_NUM_W;
    typedef logic [DIV_NUM_W-1:0] div_num_t;
    typedef logic [DIV_DEN_W-1:0] div_den_t;

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    // sin^2(pi/2 * k / 2^bits) in Q1.16, evaluated at elaboration only
    function automatic logic [FRAC_W-1:0] ease_entry(input int unsigned k,
                                                    input int unsigned bits);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] v;
        x = (HALF_PI_Q30 * 64'(k)) >> bits;
        x2 = (x * x) >> 30;
        term = x;
        sum = x;
        for (int n = 1; n <= 6; n++) begin
            case (n)
                1: term = ((term * x2) >> 30) / 64'd6;
                2: term = ((term * x2) >> 30) / 64'd20;
                3: term = ((term * x2) >> 30) / 64'd42;
                4: term = ((term * x2) >> 30) / 64'd72;
                5: term = ((term * x2) >> 30) / 64'd110;
                default: term = ((term * x2) >> 30) / 64'd156;
            endcase
            if ((n % 2) == 1)
                sum = sum - term;
            else
                sum = sum + term;
        end
        v = (sum * sum) >> 30;
        v = (v + 64'd8192) >> 14;
        return (v > 64'd65536) ? 17'd65536 : v[FRAC_W-1:0];
    endfunction

endpackage

`default_nettype wire

### rtl/servo_sine_blend_trajectory.sv
`timescale 1ns / 1ps
`default_nettype none
// Eight-channel servo trajectory generator with blended cosine/linear easing.
// Input channel (in_valid/in_ready): req_type 0 is a move word with target
// angles and move_ms, req_type 1 is a refresh tick. Output channel
// (out_valid/out_ready) carries eight pulse widths and move_done.
// A move with nonzero duration returns nothing; a zero-duration move and
// every tick return exactly one word.
// One word is worked at a time, through a shared registered multiplier and
// a one-bit-per-cycle divider (32 steps) under a small sequencer. Moves
// and ticks while moving work through the servos in turn; a tick while
// idle goes straight to the output.
// in_ready is high only while the sequencer is idle. The result sits in an
// output register, so a new word is taken while it waits; a later result
// holds the sequencer until out_ready frees that register.
// Configuration is written through cfg_we/cfg_index/cfg_data; the user must
// write it only while idle, as the block itself does not enforce this.
// Reset sets each servo's current pulse to 1500, though the pulse outputs
// are not reset; it clears any move in progress and loads the register
// defaults. The easing table is constant logic and needs no fill.

module servo_sine_blend_trajectory #(
    parameter int SERVO_COUNT    = 8,
    parameter int PULSE_BITS     = 12,
    parameter int COS_TABLE_BITS = 8
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         cfg_we,
    input  wire [ssbt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire [ssbt_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire         in_valid,
    output logic        in_ready,
    input  wire         req_type,
    input  wire [7:0]   angle_0,
    input  wire [7:0]   angle_1,
    input  wire [7:0]   angle_2,
    input  wire [7:0]   angle_3,
    input  wire [7:0]   angle_4,
    input  wire [7:0]   angle_5,
    input  wire [7:0]   angle_6,
    input  wire [7:0]   angle_7,
    input  wire [15:0]  move_ms,
    output logic        out_valid,
    input  wire         out_ready,
    output logic [11:0] pulse_0,
    output logic [11:0] pulse_1,
    output logic [11:0] pulse_2,
    output logic [11:0] pulse_3,
    output logic [11:0] pulse_4,
    output logic [11:0] pulse_5,
    output logic [11:0] pulse_6,
    output logic [11:0] pulse_7,
    output logic        move_done
);

    localparam int SV_W    = (SERVO_COUNT > 1) ? $clog2(SERVO_COUNT) : 1;
    localparam int TAB_LEN = (1 << COS_TABLE_BITS) + 1;
    localparam int K_SHIFT = ssbt_pkg::FRAC_BITS - COS_TABLE_BITS;
    localparam int K_W     = COS_TABLE_BITS + 1;
    localparam int FW      = ssbt_pkg::FRAC_W;
    localparam int OW      = ssbt_pkg::OUT_W;
    localparam int PW      = ssbt_pkg::CFG_PULSE_W;
    localparam logic [SV_W-1:0] SV_LAST = SV_W'(SERVO_COUNT - 1);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_MV_MUL1 = 4'd1;
    localparam logic [3:0] S_MV_MUL2 = 4'd2;
    localparam logic [3:0] S_MV_WB   = 4'd3;
    localparam logic [3:0] S_MV_JUMP = 4'd4;
    localparam logic [3:0] S_MV_DIV  = 4'd5;
    localparam logic [3:0] S_MV_DIVW = 4'd6;
    localparam logic [3:0] S_TK_DIV  = 4'd7;
    localparam logic [3:0] S_TK_DIVW = 4'd8;
    localparam logic [3:0] S_TK_F1   = 4'd9;
    localparam logic [3:0] S_TK_F2   = 4'd10;
    localparam logic [3:0] S_TK_F3   = 4'd11;
    localparam logic [3:0] S_TK_MUL  = 4'd12;
    localparam logic [3:0] S_TK_WB   = 4'd13;
    localparam logic [3:0] S_EMIT    = 4'd14;

    // configuration
    logic [ssbt_pkg::CFG_DATA_W-1:0] cfg_trim_reg;
    logic [PW-1:0]                   cfg_pmin_reg;
    logic [PW-1:0]                   cfg_pmax_reg;
    logic [ssbt_pkg::WEIGHT_W-1:0]   cfg_weight_reg;
    logic [ssbt_pkg::TICK_W-1:0]     cfg_tick_reg;

    // sequencer and trajectory state
    logic [3:0]            state_reg, state_next;
    logic [SV_W-1:0]       sv_reg, sv_next;
    logic [PULSE_BITS-1:0] cur_reg [SERVO_COUNT];
    logic [PULSE_BITS-1:0] cur_next [SERVO_COUNT];
    logic [PULSE_BITS-1:0] start_reg [SERVO_COUNT];
    logic [PULSE_BITS-1:0] start_next [SERVO_COUNT];
    logic [PULSE_BITS-1:0] tgt_reg [SERVO_COUNT];
    logic [PULSE_BITS-1:0] tgt_next [SERVO_COUNT];
    logic [ssbt_pkg::MS_W-1:0] idx_reg, idx_next;
    logic [ssbt_pkg::MS_W-1:0] tot_reg, tot_next;
    logic                  moving_reg, moving_next;
    logic                  out_valid_reg, out_valid_next;

    // latched input word and working values
    logic [ssbt_pkg::ANGLE_W-1:0] ang_in [ssbt_pkg::NUM_PORTS];
    logic [ssbt_pkg::ANGLE_W-1:0] ang_reg [SERVO_COUNT];
    logic [ssbt_pkg::MS_W-1:0]    ms_reg;
    logic [FW-1:0]         lin_reg, lin_next;
    logic [24:0]           acc_reg, acc_next;
    logic [FW-1:0]         f_reg, f_next;
    logic                  done_pend_reg, done_pend_next;
    logic                  out_load;
    logic [OW-1:0]         out_pulse_reg [ssbt_pkg::NUM_PORTS];
    logic [OW-1:0]         emit_val [ssbt_pkg::NUM_PORTS];
    logic                  out_done_reg;

    // shared units
    ssbt_pkg::mul_op_t  mul_a, mul_b;
    ssbt_pkg::prod_t    mul_p;
    logic               div_start;
    ssbt_pkg::div_num_t div_dividend;
    ssbt_pkg::div_den_t div_divisor;
    logic               div_done;
    ssbt_pkg::div_num_t div_quo;

    // move datapath
    logic [7:0]  sv_trim;
    logic signed [9:0] ang_sum;
    logic [ssbt_pkg::ANGLE_W-1:0] ang_cl;
    logic [PW:0]   diff;
    logic          diff_neg;
    logic [PW-1:0] diff_mag;
    logic [PW-1:0] mv_q;
    logic [16:0]   mv_val;
    logic [ssbt_pkg::TICK_W-1:0] tick_eff;
    logic [ssbt_pkg::MS_W-1:0]   idx_inc;
    logic [ssbt_pkg::MS_W-1:0]   tot_q;

    // tick datapath
    logic [FW-1:0]  ease_tab [TAB_LEN];
    logic [K_W-1:0] k_idx;
    logic [ssbt_pkg::WEIGHT_W-1:0] w_cl;
    logic [ssbt_pkg::WEIGHT_W-1:0] w_inv;
    logic [24:0]           f_sum;
    logic [PULSE_BITS-1:0] tk_s, tk_g, tk_d, tk_m, tk_new;
    logic                  tk_up;
    logic                  out_free;

    genvar g;

    // easing table, built at elaboration
    for (g = 0; g < TAB_LEN; g++)
    begin : g_ease
        localparam logic [FW-1:0] ENTRY = ssbt_pkg::ease_entry(g, COS_TABLE_BITS);
        assign ease_tab[g] = ENTRY;
    end

    assign ang_in[0] = angle_0;
    assign ang_in[1] = angle_1;
    assign ang_in[2] = angle_2;
    assign ang_in[3] = angle_3;
    assign ang_in[4] = angle_4;
    assign ang_in[5] = angle_5;
    assign ang_in[6] = angle_6;
    assign ang_in[7] = angle_7;

    ssbt_mul u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (mul_p)
    );

    ssbt_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quo)
    );

    // angle plus trim, clamped to 0..180
    assign sv_trim = cfg_trim_reg[{sv_reg, 3'b000} +: 8];
    assign ang_sum = $signed({2'b00, ang_reg[sv_reg]}) + $signed({{2{sv_trim[7]}}, sv_trim});
    assign ang_cl = ang_sum[9] ? '0
                  : (ang_sum > $signed({2'b00, ssbt_pkg::ANGLE_MAX})) ? ssbt_pkg::ANGLE_MAX
                  : ang_sum[7:0];

    assign diff = {1'b0, cfg_pmax_reg} - {1'b0, cfg_pmin_reg};
    assign diff_neg = diff[PW];
    assign diff_mag = diff_neg ? PW'(-diff) : diff[PW-1:0];
    assign mv_q = mul_p[ssbt_pkg::RECIP_SHIFT +: PW];
    assign mv_val = diff_neg ? (17'(cfg_pmin_reg) - 17'(mv_q))
                             : (17'(cfg_pmin_reg) + 17'(mv_q));

    assign tick_eff = (cfg_tick_reg == '0) ? ssbt_pkg::TICK_W'(1) : cfg_tick_reg;
    assign idx_inc = idx_reg + 1'b1;
    assign tot_q = div_quo[ssbt_pkg::MS_W-1:0];

    assign k_idx = lin_reg[FW-1:K_SHIFT];
    assign w_cl = (cfg_weight_reg > ssbt_pkg::WEIGHT_FULL) ? ssbt_pkg::WEIGHT_FULL
                                                           : cfg_weight_reg;
    assign w_inv = ssbt_pkg::WEIGHT_FULL - w_cl;
    assign f_sum = acc_reg + mul_p[24:0];

    assign tk_s = start_reg[sv_reg];
    assign tk_g = tgt_reg[sv_reg];
    assign tk_up = (tk_g > tk_s);
    assign tk_d = tk_up ? (tk_g - tk_s) : (tk_s - tk_g);
    assign tk_m = mul_p[ssbt_pkg::FRAC_BITS +: PULSE_BITS];
    assign tk_new = tk_up ? (tk_s + tk_m) : (tk_s - tk_m);

    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        sv_next = sv_reg;
        cur_next = cur_reg;
        start_next = start_reg;
        tgt_next = tgt_reg;
        idx_next = idx_reg;
        tot_next = tot_reg;
        moving_next = moving_reg;
        out_valid_next = out_valid_reg && !out_ready;
        lin_next = lin_reg;
        acc_next = acc_reg;
        f_next = f_reg;
        done_pend_next = done_pend_reg;
        out_load = 1'b0;
        mul_a = '0;
        mul_b = '0;
        div_start = 1'b0;
        div_dividend = '0;
        div_divisor = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (!req_type)
                    begin
                        sv_next = '0;
                        state_next = S_MV_MUL1;
                    end
                    else if (!moving_reg)
                    begin
                        done_pend_next = 1'b0;
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        idx_next = (idx_inc > tot_reg) ? tot_reg : idx_inc;
                        state_next = S_TK_DIV;
                    end
                end
            end
            S_MV_MUL1:
            begin
                mul_a = ssbt_pkg::mul_op_t'(ang_cl);
                mul_b = ssbt_pkg::mul_op_t'(diff_mag);
                state_next = S_MV_MUL2;
            end
            S_MV_MUL2:
            begin
                // divide by 180: drop two bits, then multiply by 1/45
                mul_a = ssbt_pkg::mul_op_t'(mul_p[19:2]);
                mul_b = ssbt_pkg::RECIP_45;
                state_next = S_MV_WB;
            end
            S_MV_WB:
            begin
                tgt_next[sv_reg] = mv_val[PULSE_BITS-1:0];
                if (sv_reg == SV_LAST)
                    state_next = (ms_reg == '0) ? S_MV_JUMP : S_MV_DIV;
                else
                begin
                    sv_next = sv_reg + 1'b1;
                    state_next = S_MV_MUL1;
                end
            end
            S_MV_JUMP:
            begin
                start_next = cur_reg;
                cur_next = tgt_reg;
                moving_next = 1'b0;
                idx_next = '0;
                tot_next = '0;
                done_pend_next = 1'b1;
                state_next = S_EMIT;
            end
            S_MV_DIV:
            begin
                start_next = cur_reg;
                div_start = 1'b1;
                div_dividend = ssbt_pkg::div_num_t'(ms_reg);
                div_divisor = ssbt_pkg::div_den_t'(tick_eff);
                state_next = S_MV_DIVW;
            end
            S_MV_DIVW:
            begin
                if (div_done)
                begin
                    tot_next = (tot_q == '0) ? ssbt_pkg::MS_W'(1) : tot_q;
                    idx_next = '0;
                    moving_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_TK_DIV:
            begin
                div_start = 1'b1;
                div_dividend = {idx_reg, {ssbt_pkg::FRAC_BITS{1'b0}}};
                div_divisor = tot_reg;
                state_next = S_TK_DIVW;
            end
            S_TK_DIVW:
            begin
                if (div_done)
                begin
                    lin_next = div_quo[FW-1:0];
                    state_next = S_TK_F1;
                end
            end
            S_TK_F1:
            begin
                mul_a = ssbt_pkg::mul_op_t'(w_cl);
                mul_b = ssbt_pkg::mul_op_t'(ease_tab[k_idx]);
                state_next = S_TK_F2;
            end
            S_TK_F2:
            begin
                acc_next = mul_p[24:0];
                mul_a = ssbt_pkg::mul_op_t'(w_inv);
                mul_b = ssbt_pkg::mul_op_t'(lin_reg);
                state_next = S_TK_F3;
            end
            S_TK_F3:
            begin
                f_next = f_sum[24:8];
                sv_next = '0;
                state_next = S_TK_MUL;
            end
            S_TK_MUL:
            begin
                mul_a = ssbt_pkg::mul_op_t'(tk_d);
                mul_b = ssbt_pkg::mul_op_t'(f_reg);
                state_next = S_TK_WB;
            end
            S_TK_WB:
            begin
                cur_next[sv_reg] = tk_new;
                if (sv_reg == SV_LAST)
                begin
                    done_pend_next = (idx_reg == tot_reg);
                    if (idx_reg == tot_reg)
                        moving_next = 1'b0;
                    state_next = S_EMIT;
                end
                else
                begin
                    sv_next = sv_reg + 1'b1;
                    state_next = S_TK_MUL;
                end
            end
            S_EMIT:
            begin
                // hold until the output register is free
                if (out_free)
                begin
                    out_load = 1'b1;
                    out_valid_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_trim_reg <= '0;
            cfg_pmin_reg <= ssbt_pkg::PMIN_RESET;
            cfg_pmax_reg <= ssbt_pkg::PMAX_RESET;
            cfg_weight_reg <= ssbt_pkg::WEIGHT_RESET;
            cfg_tick_reg <= ssbt_pkg::TICK_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                ssbt_pkg::CFG_TRIM:   cfg_trim_reg <= cfg_data;
                ssbt_pkg::CFG_PMIN:   cfg_pmin_reg <= cfg_data[PW-1:0];
                ssbt_pkg::CFG_PMAX:   cfg_pmax_reg <= cfg_data[PW-1:0];
                ssbt_pkg::CFG_WEIGHT: cfg_weight_reg <= cfg_data[ssbt_pkg::WEIGHT_W-1:0];
                ssbt_pkg::CFG_TICK:   cfg_tick_reg <= cfg_data[ssbt_pkg::TICK_W-1:0];
                default:              cfg_tick_reg <= cfg_tick_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            sv_reg <= '0;
            for (int j = 0; j < SERVO_COUNT; j++)
            begin
                cur_reg[j] <= PULSE_BITS'(ssbt_pkg::PULSE_RESET);
                start_reg[j] <= '0;
                tgt_reg[j] <= '0;
            end
            idx_reg <= '0;
            tot_reg <= '0;
            moving_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            sv_reg <= sv_next;
            cur_reg <= cur_next;
            start_reg <= start_next;
            tgt_reg <= tgt_next;
            idx_reg <= idx_next;
            tot_reg <= tot_next;
            moving_reg <= moving_next;
            out_valid_reg <= out_valid_next;
        end
    end

    for (g = 0; g < ssbt_pkg::NUM_PORTS; g++)
    begin : g_emit
        if (g < SERVO_COUNT)
        begin : g_live
            assign emit_val[g] = OW'(cur_reg[g]);
        end
        else
        begin : g_off
            assign emit_val[g] = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            for (int j = 0; j < SERVO_COUNT; j++)
                ang_reg[j] <= ang_in[j];
            ms_reg <= move_ms;
        end
        lin_reg <= lin_next;
        acc_reg <= acc_next;
        f_reg <= f_next;
        done_pend_reg <= done_pend_next;
        if (out_load)
        begin
            out_pulse_reg <= emit_val;
            out_done_reg <= done_pend_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign pulse_0 = out_pulse_reg[0];
    assign pulse_1 = out_pulse_reg[1];
    assign pulse_2 = out_pulse_reg[2];
    assign pulse_3 = out_pulse_reg[3];
    assign pulse_4 = out_pulse_reg[4];
    assign pulse_5 = out_pulse_reg[5];
    assign pulse_6 = out_pulse_reg[6];
    assign pulse_7 = out_pulse_reg[7];
    assign move_done = out_done_reg;

endmodule

`default_nettype wire

### rtl/ssbt_div.sv
`timescale 1ns / 1ps
`default_nettype none

module ssbt_div (
    input  wire                        clk,
    input  wire                        rst_n,
    input  wire                        start,
    input  wire [ssbt_pkg::DIV_NUM_W-1:0] dividend,
    input  wire [ssbt_pkg::DIV_DEN_W-1:0] divisor,
    output logic                       done,
    output logic [ssbt_pkg::DIV_NUM_W-1:0] quotient
);

    localparam int CNT_W = $clog2(ssbt_pkg::DIV_STEPS);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(ssbt_pkg::DIV_STEPS - 1);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    ssbt_pkg::div_den_t   rem_reg, rem_next;
    ssbt_pkg::div_num_t   quo_reg, quo_next;
    ssbt_pkg::div_den_t   den_reg, den_next;
    logic [ssbt_pkg::DIV_DEN_W:0] shifted;
    logic                 fits;

    // one quotient bit per cycle, restoring
    assign shifted = {rem_reg, quo_reg[ssbt_pkg::DIV_NUM_W-1]};
    assign fits = (shifted >= {1'b0, den_reg});

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next = cnt_reg;
        rem_next = rem_reg;
        quo_next = quo_reg;
        den_next = den_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next = '0;
            rem_next = '0;
            quo_next = dividend;
            den_next = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? ssbt_pkg::DIV_DEN_W'(shifted - {1'b0, den_reg})
                            : ssbt_pkg::DIV_DEN_W'(shifted);
            quo_next = {quo_reg[ssbt_pkg::DIV_NUM_W-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign done = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

### rtl/ssbt_mul.sv
`timescale 1ns / 1ps
`default_nettype none

module ssbt_mul (
    input  wire                       clk,
    input  wire [ssbt_pkg::MUL_W-1:0] a,
    input  wire [ssbt_pkg::MUL_W-1:0] b,
    output logic [ssbt_pkg::PROD_W-1:0] p
);

    ssbt_pkg::prod_t p_reg;

    always_ff @(posedge clk)
    begin
        p_reg <= ssbt_pkg::PROD_W'(a) * ssbt_pkg::PROD_W'(b);
    end

    assign p = p_reg;

endmodule

`default_nettype wire

### rtl/ssbt_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "servo_sine_blend_trajectory_defines.svh"

module ssbt_checker (
    input wire        clk,
    input wire        rst_n,
    input wire        in_valid,
    input wire        in_ready,
    input wire        out_valid,
    input wire        out_ready,
    input wire [11:0] pulse_0,
    input wire        move_done
);

    // a taken word keeps the block busy for at least the next cycle
    `SSBT_ASSERT_NEXT(a_busy_after_take, in_valid && in_ready, !in_ready)

    // a stalled result word holds
    `SSBT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
                      out_valid && $stable(pulse_0) && $stable(move_done))

    // a new result word is only loaded while the sequencer is busy
    `SSBT_ASSERT_SAME(a_load_when_busy, $rose(out_valid), $past(!in_ready))

endmodule

bind servo_sine_blend_trajectory ssbt_checker u_ssbt_checker (.*);

`default_nettype wire
